>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the two-list merge block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/smtl_pkg.sv
// Shared types and constants for the sorted two-list merge block.
// No dependencies; imported by every module of the block.
package smtl_pkg;

	localparam int VALUE_W        = 32;
	localparam int LIST_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	typedef struct packed {
		logic               which;
		logic [VALUE_W-1:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic merging;
		logic emit_last;
	} status_t;

endpackage

>>> rtl/core/smtl_queue.sv
// Front of the merge block: accepts input items into a short queue.
// Depends on smtl_pkg.
module smtl_queue import smtl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  item_t s_item,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);

	localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QC_W-1:0] FULL_C = QC_W'(QUEUE_DEPTH);

	item_t            slots_q [QUEUE_DEPTH];
	logic [QP_W-1:0]  wr_ptr_q;
	logic [QP_W-1:0]  rd_ptr_q;
	logic [QC_W-1:0]  count_q;
	logic             push;
	logic             pop;

	assign s_tready = (count_q != FULL_C);
	assign q_valid  = (count_q != '0);
	assign q_item   = slots_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= s_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QC_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QC_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/smtl_merge.sv
// Back of the merge block: stores list elements in two buffers and,
// once both lists end, emits the merged sequence. Depends on smtl_pkg.
module smtl_merge import smtl_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_value,
	output logic               m_from,
	output logic               m_last,
	output logic               m_ovf,
	output status_t            status
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

	typedef enum logic [1:0] {ST_LOAD, ST_START, ST_MERGE} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] mem_a [LIST_DEPTH];
	logic [VALUE_W-1:0] mem_b [LIST_DEPTH];
	logic [CNT_W-1:0]   cnt_a_q, cnt_b_q, i_q, j_q;
	logic               end_a_q, end_b_q, drop_q;
	logic [VALUE_W-1:0] head_a_q, head_b_q;
	logic               m_tvalid_q, m_last_q, m_from_q, m_ovf_q;
	logic [VALUE_W-1:0] m_value_q;

	logic             load_go, sel, cur_end, store, end_set, end_a_n, end_b_n;
	logic [CNT_W-1:0] cur_cnt, i_n, j_n, i_d, j_d;
	logic             out_free, step, avail_a, avail_b, take_a, is_last;

	always_comb begin
		load_go  = (state_q == ST_LOAD) && q_valid;
		sel      = q_item.which;
		cur_end  = sel ? end_b_q : end_a_q;
		cur_cnt  = sel ? cnt_b_q : cnt_a_q;
		store    = load_go && !cur_end && (cur_cnt < DEPTH_C);
		end_set  = load_go && !cur_end && q_item.last;
		end_a_n  = end_a_q || (end_set && !sel);
		end_b_n  = end_b_q || (end_set && sel);

		out_free = !m_tvalid_q || m_tready;
		step     = (state_q == ST_MERGE) && out_free;
		avail_a  = (i_q < cnt_a_q);
		avail_b  = (j_q < cnt_b_q);
		take_a   = avail_a && (!avail_b || ($signed(head_a_q) <= $signed(head_b_q)));
		i_n      = i_q + CNT_W'(take_a);
		j_n      = j_q + CNT_W'(!take_a);
		is_last  = step && (i_n == cnt_a_q) && (j_n == cnt_b_q);
		i_d      = step ? i_n : i_q;
		j_d      = step ? j_n : j_q;
	end

	assign q_pop            = load_go;
	assign m_tvalid         = m_tvalid_q;
	assign m_value          = m_value_q;
	assign m_from           = m_from_q;
	assign m_last           = m_last_q;
	assign m_ovf            = m_ovf_q;
	assign status.merging   = (state_q != ST_LOAD);
	assign status.emit_last = is_last;

	// buffers: one write port, registered read of the current heads
	always_ff @(posedge clk) begin
		if (store && !sel) begin
			mem_a[cur_cnt[IDX_W-1:0]] <= q_item.value;
		end
		if (store && sel) begin
			mem_b[cur_cnt[IDX_W-1:0]] <= q_item.value;
		end
		head_a_q <= mem_a[i_d[IDX_W-1:0]];
		head_b_q <= mem_b[j_d[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_a_q    <= '0;
			cnt_b_q    <= '0;
			end_a_q    <= 1'b0;
			end_b_q    <= 1'b0;
			drop_q     <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			m_tvalid_q <= 1'b0;
			m_value_q  <= '0;
			m_from_q   <= 1'b0;
			m_last_q   <= 1'b0;
			m_ovf_q    <= 1'b0;
		end else begin
			if (step) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (load_go) begin
						if (store && !sel) begin
							cnt_a_q <= cnt_a_q + CNT_W'(1);
						end
						if (store && sel) begin
							cnt_b_q <= cnt_b_q + CNT_W'(1);
						end
						if (!store) begin
							drop_q <= 1'b1;
						end
						end_a_q <= end_a_n;
						end_b_q <= end_b_n;
						if (end_a_n && end_b_n) begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					if ((cnt_a_q == '0) && (cnt_b_q == '0)) begin
						end_a_q <= 1'b0;
						end_b_q <= 1'b0;
						drop_q  <= 1'b0;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (step) begin
						m_value_q  <= take_a ? head_a_q : head_b_q;
						m_from_q   <= !take_a;
						m_last_q   <= is_last;
						m_ovf_q    <= drop_q;
						if (is_last) begin
							i_q     <= '0;
							j_q     <= '0;
							cnt_a_q <= '0;
							cnt_b_q <= '0;
							end_a_q <= 1'b0;
							end_b_q <= 1'b0;
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							i_q     <= i_n;
							j_q     <= j_n;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/sorted_two_list_merge.sv
// Sorted two-list merge, top level. Depends on smtl_pkg, smtl_queue, smtl_merge.
// Load: one item per cycle while loading, through a 2-entry queue; the back pops each accepted
// item and stores it in its list buffer. Merge: after the item that ends the second list is
// stored, a setup state follows (back to loading if both lists are empty); results are registered,
// one result per cycle while m_tready is high. Input stalls once the queue fills during a merge.
// Async reset clears queue, counts, flags and output valid; buffers are not cleared.
module sorted_two_list_merge import smtl_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] s_tdata,  // [31:0] value
	input  logic               s_tuser,  // [0] which_list
	input  logic               s_tlast,  // last_of_list
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata,  // [31:0] merged_value
	output logic [1:0]         m_tuser,  // [0] from_list, [1] overflow_seen
	output logic               m_tlast   // last_merged
);

	item_t   s_item;
	item_t   q_item;
	logic    q_valid;
	logic    q_pop;
	logic    m_from;
	logic    m_ovf;
	status_t status;

	assign s_item.which = s_tuser;
	assign s_item.value = s_tdata;
	assign s_item.last  = s_tlast;
	assign m_tuser      = {m_ovf, m_from};

	smtl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	smtl_merge #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_value  (m_tdata),
		.m_from   (m_from),
		.m_last   (m_tlast),
		.m_ovf    (m_ovf),
		.status   (status)
	);

`include "assert_macros.svh"

	`ASSERT_IMPLY(a_pop_needs_item, clk, arst_n, q_pop, q_valid)
	`ASSERT_IMPLY(a_no_load_in_merge, clk, arst_n, status.merging, !q_pop)
	`ASSERT_NEXT(a_last_ends_merge, clk, arst_n, status.emit_last,
		!status.merging && m_tvalid && m_tlast)

endmodule
